// File: hw/rtl/cpht_pkg.sv
// Shared types, codes and field widths of the cubic-probe hash table.
package cpht_pkg;

   localparam int KEY_W         = 64;
   localparam int VALUE_W       = 32;
   localparam int CMD_W         = 2;
   localparam int STATUS_W      = 2;
   localparam int MARK_W        = 2;
   localparam int ENTRY_COUNT_W = 12;
   localparam int HASH_BASE     = 37;

   // Request payload: key, amount. Response payload: status, value, entry_count.
   localparam int REQ_TDATA_W = KEY_W + VALUE_W;
   localparam int RSP_FIELD_W = STATUS_W + VALUE_W + ENTRY_COUNT_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_CREATE = 2'd3
   } cmd_type;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LIMIT     = 2'd2;

   localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
   localparam logic [MARK_W-1:0] MARK_LIVE  = 2'd1;
   localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

   localparam logic [VALUE_W-1:0] VALUE_MISS = '1;

   typedef struct packed {
      logic [MARK_W-1:0]  mark;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } slot_entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH_MUL,
      ST_HASH_RED,
      ST_PROBE,
      ST_EVAL
   } state_type;

endpackage

// File: hw/rtl/cpht_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module cpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/cubic_probe_hash_table.sv
// Top level of the open-addressing key/value table with cubic probing.
//
// Requests arrive on the req_ channel: req_tuser carries the command (lookup,
// add, delete, create) and req_tdata the key and the signed amount. Every
// request produces exactly one response on the rsp_ channel with a status,
// the stored value after the operation and the number of live entries.
//
// The block works on one request at a time. The home slot is hashed one key
// byte at a time, each in ST_HASH_MUL (one multiply by a fixed reciprocal)
// and then ST_HASH_RED (a small correction). Each probe then passes through
// ST_PROBE, which addresses the slot memory, and ST_EVAL, which checks the
// returned entry and writes it back. The next request is taken in ST_IDLE,
// once the last one has settled and been placed in the output register.
//
// After reset the block sweeps the slot memory once, marking every slot
// empty; req_tready stays low until the sweep is done.
// Results sit in an output register. A new request is taken while a result
// still waits; if the receiver stalls long enough, the next request holds in
// its last probe until the output register frees up.
module cubic_probe_hash_table import cpht_pkg::*; #(
   parameter int SLOT_COUNT = 4093,
   parameter int KEY_BYTES  = 8,
   parameter int MAX_PROBES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // key [63:0], amount [95:64]
   input  logic [CMD_W-1:0]       req_tuser,  // command [1:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // status [1:0], value [33:2],
                                              // entry_count [45:34], zero pad
);

   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
   localparam int BYTE_IDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
   localparam int PROBE_W    = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
   // Horner step value h*37 + byte stays below X_MAX + 1.
   localparam int X_MAX      = HASH_BASE * (SLOT_COUNT - 1) + 255;
   localparam int X_W        = $clog2(X_MAX + 1);
   // Reciprocal that gives the quotient exactly or one too high.
   localparam int RECIP      = (2 ** X_W) / SLOT_COUNT + 1;
   localparam int RECIP_W    = $clog2(RECIP + 1);
   localparam int PROD_W     = X_W + RECIP_W;
   localparam int Q_W        = $clog2(X_MAX / SLOT_COUNT + 2);
   localparam int ENTRY_W    = $bits(slot_entry_type);
   localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (8 * (8 - KEY_BYTES));
   localparam logic [BYTE_IDX_W-1:0] LAST_BYTE = BYTE_IDX_W'(KEY_BYTES - 1);
   localparam logic [PROBE_W-1:0]    LAST_PROBE = PROBE_W'(MAX_PROBES - 1);
   localparam logic [SLOT_W-1:0]     LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

   // Sum of two residues, reduced once.
   function automatic logic [SLOT_W-1:0] add_mod(input logic [SLOT_W-1:0] a,
                                                 input logic [SLOT_W-1:0] b);
      logic [SLOT_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (SLOT_W + 1)'(SLOT_COUNT)) begin
         sum = sum - (SLOT_W + 1)'(SLOT_COUNT);
      end
      return sum[SLOT_W-1:0];
   endfunction

   state_type state_ff, state_in;

   // Request held for the whole operation.
   cmd_type              cmd_ff, cmd_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [VALUE_W-1:0]   amount_ff, amount_in;

   // Hash datapath.
   logic [BYTE_IDX_W-1:0] byte_idx_ff, byte_idx_in;
   logic [SLOT_W-1:0]     hash_ff, hash_in;
   logic [X_W-1:0]        x_ff, x_in;
   logic [Q_W-1:0]        q_ff, q_in;

   // Probe walk: cube of the probe index and its running differences, all mod N.
   logic [SLOT_W-1:0]  cube_ff, cube_in;
   logic [SLOT_W-1:0]  diff1_ff, diff1_in;
   logic [SLOT_W-1:0]  diff2_ff, diff2_in;
   logic [PROBE_W-1:0] probe_cnt_ff, probe_cnt_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;

   logic [SLOT_W-1:0]  clear_addr_ff, clear_addr_in;
   logic [CNT_W-1:0]   live_count_ff, live_count_in;

   // Output register.
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]       rsp_value_ff, rsp_value_in;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // Slot memory port.
   logic                  ram_wr_en;
   logic [SLOT_W-1:0]     ram_wr_addr;
   slot_entry_type        ram_wr_entry;
   logic                  ram_rd_en;
   logic [SLOT_W-1:0]     ram_rd_addr;
   logic [ENTRY_W-1:0]    ram_rd_data;
   slot_entry_type        rd_entry;

   // Combinational helpers.
   logic [KEY_BYTES-1:0] byte_live;
   logic [7:0]           cur_byte;
   logic [X_W-1:0]       horner_x;
   logic [PROD_W-1:0]    horner_prod;
   logic [X_W:0]         red_diff;
   logic [X_W:0]         red_rem;
   logic [SLOT_W-1:0]    probe_slot;
   logic                 out_free;
   logic                 is_empty;
   logic                 is_hit;
   logic                 at_limit;
   logic [VALUE_W-1:0]   sum_value;

   cpht_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = slot_entry_type'(ram_rd_data);

   // A key byte counts only if it and every byte below it are nonzero.
   always_comb begin
      for (int b = 0; b < KEY_BYTES; b++) begin
         if (b == 0) begin
            byte_live[b] = (key_ff[7:0] != 8'd0);
         end else begin
            byte_live[b] = byte_live[b-1] && (key_ff[8*b +: 8] != 8'd0);
         end
      end
   end

   // Horner form, highest byte first: h = (h*37 + byte) mod N.
   assign cur_byte    = byte_live[byte_idx_ff] ? key_ff[8*byte_idx_ff +: 8] : 8'd0;
   assign horner_x    = X_W'(hash_ff) * X_W'(HASH_BASE) + X_W'(cur_byte);
   assign horner_prod = PROD_W'(horner_x) * PROD_W'(RECIP);
   assign red_diff    = {1'b0, x_ff} - (X_W + 1)'((X_W + 1)'(q_ff) * (X_W + 1)'(SLOT_COUNT));
   assign red_rem     = red_diff[X_W] ? red_diff + (X_W + 1)'(SLOT_COUNT) : red_diff;

   assign probe_slot = add_mod(hash_ff, cube_ff);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign is_empty   = (rd_entry.mark == MARK_EMPTY);
   assign is_hit     = (cmd_ff != CMD_CREATE) && (rd_entry.mark == MARK_LIVE)
                       && (rd_entry.key == key_ff);
   assign at_limit   = (probe_cnt_ff == LAST_PROBE);
   assign sum_value  = rd_entry.value + amount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         live_count_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         live_count_ff <= live_count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      amount_ff     <= amount_in;
      byte_idx_ff   <= byte_idx_in;
      hash_ff       <= hash_in;
      x_ff          <= x_in;
      q_ff          <= q_in;
      cube_ff       <= cube_in;
      diff1_ff      <= diff1_in;
      diff2_ff      <= diff2_in;
      probe_cnt_ff  <= probe_cnt_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      amount_in     = amount_ff;
      byte_idx_in   = byte_idx_ff;
      hash_in       = hash_ff;
      x_in          = x_ff;
      q_in          = q_ff;
      cube_in       = cube_ff;
      diff1_in      = diff1_ff;
      diff2_in      = diff2_ff;
      probe_cnt_in  = probe_cnt_ff;
      slot_in       = slot_ff;
      clear_addr_in = clear_addr_ff;
      live_count_in = live_count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      req_tready    = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = slot_ff;
      ram_wr_entry  = '{mark: MARK_LIVE, key: key_ff, value: amount_ff};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = probe_slot;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = clear_addr_ff;
            ram_wr_entry  = '{mark: MARK_EMPTY, key: '0, value: '0};
            clear_addr_in = clear_addr_ff + SLOT_W'(1);
            if (clear_addr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in      = cmd_type'(req_tuser);
               key_in      = req_tdata[KEY_W-1:0] & KEY_MASK;
               amount_in   = req_tdata[KEY_W +: VALUE_W];
               byte_idx_in = LAST_BYTE;
               hash_in     = '0;
               state_in    = ST_HASH_MUL;
            end
         end
         ST_HASH_MUL: begin
            x_in     = horner_x;
            q_in     = Q_W'(horner_prod >> X_W);
            state_in = ST_HASH_RED;
         end
         ST_HASH_RED: begin
            hash_in = red_rem[SLOT_W-1:0];
            if (byte_idx_ff == '0) begin
               cube_in      = '0;
               diff1_in     = SLOT_W'(1);
               diff2_in     = SLOT_W'(6);
               probe_cnt_in = '0;
               state_in     = ST_PROBE;
            end else begin
               byte_idx_in = byte_idx_ff - BYTE_IDX_W'(1);
               state_in    = ST_HASH_MUL;
            end
         end
         ST_PROBE: begin
            ram_rd_en = 1'b1;
            slot_in   = probe_slot;
            state_in  = ST_EVAL;
         end
         ST_EVAL: begin
            if (is_empty || is_hit || at_limit) begin
               // Settled: commit the write-back and the result together,
               // which waits for room in the output register.
               if (out_free) begin
                  rsp_tvalid_in = 1'b1;
                  rsp_status_in = STATUS_OK;
                  rsp_value_in  = VALUE_MISS;
                  state_in      = ST_IDLE;
                  if (is_empty) begin
                     if (cmd_ff inside {CMD_ADD, CMD_CREATE}) begin
                        ram_wr_en     = 1'b1;
                        live_count_in = live_count_ff + CNT_W'(1);
                        rsp_value_in  = amount_ff;
                     end else begin
                        rsp_status_in = STATUS_NOT_FOUND;
                     end
                  end else if (is_hit) begin
                     case (cmd_ff)
                        CMD_LOOKUP: begin
                           rsp_value_in = rd_entry.value;
                        end
                        CMD_ADD: begin
                           ram_wr_en    = 1'b1;
                           ram_wr_entry = '{mark: MARK_LIVE, key: key_ff, value: sum_value};
                           rsp_value_in = sum_value;
                        end
                        CMD_DELETE: begin
                           ram_wr_en     = 1'b1;
                           ram_wr_entry  = '{mark: MARK_TOMB, key: key_ff, value: '0};
                           live_count_in = live_count_ff - CNT_W'(1);
                           rsp_value_in  = '0;
                        end
                        default: begin
                           rsp_status_in = STATUS_LIMIT;
                        end
                     endcase
                  end else begin
                     rsp_status_in = STATUS_LIMIT;
                  end
                  rsp_count_in = ENTRY_COUNT_W'(live_count_in);
               end
            end else begin
               // Step to the next cube: c += d1, d1 += d2, d2 += 6 (all mod N).
               cube_in      = add_mod(cube_ff, diff1_ff);
               diff1_in     = add_mod(diff1_ff, diff2_ff);
               diff2_in     = add_mod(diff2_ff, SLOT_W'(6));
               probe_cnt_in = probe_cnt_ff + PROBE_W'(1);
               state_in     = ST_PROBE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_count_ff, rsp_value_ff, rsp_status_ff};

endmodule

// File: hw/rtl/cpht_checker.sv
// Port-level checks of the hash table and the bind that attaches them.
module cpht_checker import cpht_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // A stalled response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // The memory sweep after reset blocks requests.
   assert property (@(posedge clock) $past(reset) |-> !req_tready)
      else $error("request taken during the clearing sweep");

   // One request at a time: the block is busy right after taking one.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another was in flight");

   // A miss or a probe-limit response carries the all-ones value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != STATUS_OK) |-> rsp_tdata[33:2] == VALUE_MISS)
      else $error("failed response with a stored value");

endmodule

bind cubic_probe_hash_table cpht_checker u_cpht_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
